FILE: hw/rtl/ssfr_pkg.sv
// Shared constants and control types for the start/stop frame receiver.
package ssfr_pkg;

  localparam int DATA_W           = 8;
  localparam int POS_W            = 6;
  localparam int LEN_W            = 7;
  localparam int CFG_IDX_W        = 2;
  localparam int DEF_BUFFER_DEPTH = 64;

  localparam logic [DATA_W-1:0] START_DELIM_RST = 8'd2;
  localparam logic [DATA_W-1:0] STOP_DELIM_RST  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_DELIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DELIM  = 2'd1;

  typedef struct packed {
    logic cmd_cap;
    logic wr_en;
    logic ovf_set;
    logic rd_first;
    logic rd_en;
    logic idx_inc;
    logic load_data;
    logic load_empty;
    logic clear_frame;
  } ssfr_cmd_t;

  typedef struct packed {
    logic rx_is_start;
    logic rx_is_stop;
    logic buf_full;
    logic count_zero;
    logic is_last;
    logic out_free;
  } ssfr_status_t;

endpackage

FILE: hw/rtl/ssfr_ctrl.sv
// Controller state machine for the start/stop frame receiver.
module ssfr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ssfr_pkg::ssfr_status_t sts_i,
  output ssfr_pkg::ssfr_cmd_t    cmd_o
);
  import ssfr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_DATA  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  assign in_stall_o = (state_q inside {S_RD, S_LD, S_EMPTY});
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && sts_i.rx_is_start) begin
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        if (in_fire) begin
          cmd_o.cmd_cap = 1'b1;
          state_d       = S_DATA;
        end
      end
      S_DATA: begin
        if (in_fire) begin
          if (sts_i.rx_is_stop) begin
            cmd_o.rd_first = 1'b1;
            state_d        = sts_i.count_zero ? S_EMPTY : S_RD;
          end else if (!sts_i.buf_full) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.ovf_set = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_LD;
      end
      S_LD: begin
        if (sts_i.out_free) begin
          cmd_o.load_data = 1'b1;
          if (sts_i.is_last) begin
            cmd_o.clear_frame = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.load_empty  = 1'b1;
          cmd_o.clear_frame = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/ssfr_datapath.sv
// Datapath: delimiter registers, payload buffer, frame counters and result register.
module ssfr_datapath #(
  parameter int BUFFER_DEPTH = ssfr_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ssfr_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic [ssfr_pkg::DATA_W-1:0]    rx_byte_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [ssfr_pkg::DATA_W-1:0]    frame_command_o,
  output logic [ssfr_pkg::DATA_W-1:0]    payload_byte_o,
  output logic [ssfr_pkg::POS_W-1:0]     byte_position_o,
  output logic [ssfr_pkg::LEN_W-1:0]     frame_length_o,
  output logic                           empty_frame_o,
  output logic                           overflowed_o,
  output logic                           last_of_frame_o,
  input  ssfr_pkg::ssfr_cmd_t            cmd_i,
  output ssfr_pkg::ssfr_status_t         sts_o
);
  import ssfr_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [BUFFER_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] start_q, stop_q, cmd_q;
  logic [LEN_W-1:0]  fill_q;
  logic              ovf_q;
  logic [AW-1:0]     idx_q;
  logic [LEN_W-1:0]  idx_next;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_cmd_q, out_byte_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [LEN_W-1:0]  out_len_q;
  logic              out_empty_q, out_ovf_q, out_last_q;

  assign cfg_ready_o = 1'b1;
  assign idx_next    = LEN_W'(idx_q) + LEN_W'(1);

  assign sts_o.rx_is_start = (rx_byte_i == start_q);
  assign sts_o.rx_is_stop  = (rx_byte_i == stop_q);
  assign sts_o.buf_full    = (fill_q == LEN_W'(BUFFER_DEPTH));
  assign sts_o.count_zero  = (fill_q == '0);
  assign sts_o.is_last     = (idx_next == fill_q);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_DELIM_RST;
      stop_q  <= STOP_DELIM_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_START_DELIM: start_q <= cfg_data_i;
        REG_STOP_DELIM:  stop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q  <= '0;
      fill_q <= '0;
      ovf_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (cmd_i.cmd_cap) begin
        cmd_q <= rx_byte_i;
      end
      if (cmd_i.wr_en) begin
        fill_q <= fill_q + LEN_W'(1);
      end
      if (cmd_i.ovf_set) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.rd_first) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.clear_frame) begin
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end
    end
  end

  // payload buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[fill_q[AW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_data || cmd_i.load_empty) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_data || cmd_i.load_empty) begin
      out_cmd_q   <= cmd_q;
      out_byte_q  <= cmd_i.load_data ? rdata_q : '0;
      out_pos_q   <= cmd_i.load_data ? POS_W'(idx_q) : '0;
      out_len_q   <= fill_q;
      out_empty_q <= cmd_i.load_empty;
      out_ovf_q   <= ovf_q;
      out_last_q  <= cmd_i.load_empty || sts_o.is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_command_o = out_cmd_q;
  assign payload_byte_o  = out_byte_q;
  assign byte_position_o = out_pos_q;
  assign frame_length_o  = out_len_q;
  assign empty_frame_o   = out_empty_q;
  assign overflowed_o    = out_ovf_q;
  assign last_of_frame_o = out_last_q;

endmodule

FILE: hw/rtl/start_stop_frame_receiver_unit.sv
// Top level of the start/stop delimited frame receiver.
//
//  channel  direction  handshake               payload
//  rx       in         in_valid_i / in_stall_o  rx_byte_i
//  result   out        out_valid_o / out_stall_i frame_command_o .. last_of_frame_o
//  config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A received byte is accepted whenever no frame is being replayed; rx stalls
// during replay. A stop byte replays the frame one result at a time (buffer
// read, then result register load); an empty frame gives one empty result.
// The result register holds while out_stall_i is high; rx bytes are still
// taken while the final result of a frame waits.
// Reset restores delimiters to 2 and 3 and returns to idle.
module start_stop_frame_receiver_unit #(
  parameter int BUFFER_DEPTH = ssfr_pkg::DEF_BUFFER_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ssfr_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ssfr_pkg::DATA_W-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ssfr_pkg::DATA_W-1:0]    frame_command_o,
  output logic [ssfr_pkg::DATA_W-1:0]    payload_byte_o,
  output logic [ssfr_pkg::POS_W-1:0]     byte_position_o,
  output logic [ssfr_pkg::LEN_W-1:0]     frame_length_o,
  output logic                           empty_frame_o,
  output logic                           overflowed_o,
  output logic                           last_of_frame_o
);
  import ssfr_pkg::*;

  ssfr_cmd_t    cmd;
  ssfr_status_t sts;

  ssfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssfr_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .frame_command_o (frame_command_o),
    .payload_byte_o  (payload_byte_o),
    .byte_position_o (byte_position_o),
    .frame_length_o  (frame_length_o),
    .empty_frame_o   (empty_frame_o),
    .overflowed_o    (overflowed_o),
    .last_of_frame_o (last_of_frame_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

FILE: hw/rtl/ssfr_checker.sv
// Port-level checks for the frame receiver, bound to the top level.
module ssfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] byte_position_o,
  input logic [6:0] frame_length_o,
  input logic       empty_frame_o,
  input logic       last_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_empty_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |->
      frame_length_o == 7'd0 && last_of_frame_o && byte_position_o == 6'd0)
    else $error("malformed empty frame result");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_frame_o |-> {1'b0, byte_position_o} < frame_length_o)
    else $error("position beyond frame length");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_frame_o |->
      last_of_frame_o == ({1'b0, byte_position_o} + 7'd1 == frame_length_o))
    else $error("last marker mismatch");

endmodule

bind start_stop_frame_receiver_unit ssfr_checker u_ssfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .byte_position_o (byte_position_o),
  .frame_length_o  (frame_length_o),
  .empty_frame_o   (empty_frame_o),
  .last_of_frame_o (last_of_frame_o)
);

FILE: tb/sv/start_stop_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the start/stop frame receiver unit.
module start_stop_frame_receiver_unit_tb;
  import ssfr_pkg::*;

  localparam int DEPTH = DEF_BUFFER_DEPTH;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // past the register list
  localparam int MAX_SHOWN = 40;

  typedef enum logic [1:0] {RX_HUNT, RX_CMD, RX_BODY} rx_phase_e;
  typedef enum logic [1:0] {ROW_RX, ROW_FILL, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] cmd;
    logic [DATA_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              empty;
    logic              ovf;
    logic              last;
  } frame_rec_t;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    value;  // rx byte, fill count or register data
    logic                 typed;
    frame_rec_t           rec;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [DATA_W-1:0]    rx_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [DATA_W-1:0]    frame_command_o;
  logic [DATA_W-1:0]    payload_byte_o;
  logic [POS_W-1:0]     byte_position_o;
  logic [LEN_W-1:0]     frame_length_o;
  logic                 empty_frame_o;
  logic                 overflowed_o;
  logic                 last_of_frame_o;

  start_stop_frame_receiver_unit #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_command_o(frame_command_o),
    .payload_byte_o (payload_byte_o),
    .byte_position_o(byte_position_o),
    .frame_length_o (frame_length_o),
    .empty_frame_o  (empty_frame_o),
    .overflowed_o   (overflowed_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // receiver shadow state
  rx_phase_e         m_phase;
  logic [DATA_W-1:0] m_cmd;
  logic [DATA_W-1:0] m_start;
  logic [DATA_W-1:0] m_stop;
  logic [DATA_W-1:0] m_store [DEPTH];
  logic [LEN_W-1:0]  m_fill;
  logic              m_ovf;

  frame_rec_t step_recs[$];
  frame_rec_t owed_recs[$];
  stim_row_t  plan[$];

  int gap_pct;
  int stall_pct;
  int errors;
  int recs_seen;
  int bytes_sent;
  int frames_sent;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic void frame_track(input logic [DATA_W-1:0] b);
    frame_rec_t r;
    int i;
    step_recs = {};
    case (m_phase)
      RX_CMD: begin
        m_cmd   = b;
        m_phase = RX_BODY;
      end
      RX_BODY: begin
        if (b == m_stop) begin
          if (m_fill == 0) begin
            r = '{m_cmd, '0, '0, '0, 1'b1, m_ovf, 1'b1};
            step_recs.push_back(r);
          end else begin
            for (i = 0; i < m_fill; i++) begin
              r = '{m_cmd, m_store[i], POS_W'(i), m_fill, 1'b0, m_ovf, (i == m_fill - 1)};
              step_recs.push_back(r);
            end
          end
          m_fill  = '0;
          m_ovf   = 1'b0;
          m_phase = RX_HUNT;
        end else if (m_fill < DEPTH) begin
          m_store[m_fill[POS_W-1:0]] = b;
          m_fill++;
        end else begin
          m_ovf = 1'b1;
        end
      end
      default: begin
        m_phase = (b == m_start) ? RX_CMD : RX_HUNT;
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] body_byte();
    logic [DATA_W-1:0] b;
    b = DATA_W'($urandom_range(255));
    return (b == m_stop) ? ~b : b;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [DATA_W-1:0] value,
                                  input logic [CFG_IDX_W-1:0] idx = '0,
                                  input logic typed = 1'b0, input frame_rec_t rec = '0);
    stim_row_t row;
    row = '{kind, idx, value, typed, rec};
    plan.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= MAX_SHOWN) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] b, input logic typed = 1'b0,
                           input frame_rec_t rec = '0);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    frame_track(b);
    if (typed) owed_recs.push_back(rec);
    else foreach (step_recs[k]) owed_recs.push_back(step_recs[k]);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // only with the unit quiet: every owed result out, then a short settle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    in_valid_i <= 1'b0;
    while (owed_recs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_START_DELIM) m_start = value;
    else if (idx == REG_STOP_DELIM) m_stop = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame();
    int n;
    logic [DATA_W-1:0] b;
    repeat ($urandom_range(2)) begin
      b = DATA_W'($urandom_range(255));
      send_byte((b == m_start) ? ~b : b);
    end
    send_byte(m_start);
    send_byte(DATA_W'($urandom_range(255)));
    n = ($urandom_range(24) == 0) ? $urandom_range(70, 60) : $urandom_range(12);
    repeat (n) send_byte(body_byte());
    if ($urandom_range(9) != 0) send_byte(m_stop);  // else left open into the next frame
    frames_sent++;
  endtask

  always @(posedge clk_i) begin : result_check
    frame_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      recs_seen++;
      if (owed_recs.size() == 0) begin
        flag_mismatch("result transfer with nothing owed");
      end else begin
        want = owed_recs.pop_front();
        if (frame_command_o !== want.cmd)
          flag_mismatch($sformatf("frame_command %h, want %h", frame_command_o, want.cmd));
        if (payload_byte_o !== want.data)
          flag_mismatch($sformatf("payload_byte %h, want %h", payload_byte_o, want.data));
        if (byte_position_o !== want.pos)
          flag_mismatch($sformatf("byte_position %0d, want %0d", byte_position_o, want.pos));
        if (frame_length_o !== want.len)
          flag_mismatch($sformatf("frame_length %0d, want %0d", frame_length_o, want.len));
        if (empty_frame_o !== want.empty)
          flag_mismatch($sformatf("empty_frame %b, want %b", empty_frame_o, want.empty));
        if (overflowed_o !== want.ovf)
          flag_mismatch($sformatf("overflowed %b, want %b", overflowed_o, want.ovf));
        if (last_of_frame_o !== want.last)
          flag_mismatch($sformatf("last_of_frame %b, want %b", last_of_frame_o, want.last));
      end
    end
  end

  initial begin : run_limit
    #20_000_000;
    $display("timeout with %0d results still owed", owed_recs.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int target;
    int ph;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    gap_pct     = 8;
    stall_pct   = 64;
    errors      = 0;
    recs_seen   = 0;
    bytes_sent  = 0;
    frames_sent = 0;
    m_phase     = RX_HUNT;
    m_cmd       = '0;
    m_start     = START_DELIM_RST;
    m_stop      = STOP_DELIM_RST;
    m_fill      = '0;
    m_ovf       = 1'b0;

    // empty frame right after reset
    add_row(ROW_RX, START_DELIM_RST);
    add_row(ROW_RX, 8'hFF);
    add_row(ROW_RX, STOP_DELIM_RST, '0, 1'b1, '{8'hFF, 8'h00, '0, '0, 1'b1, 1'b0, 1'b1});
    // stop value as command, start value inside the payload
    add_row(ROW_RX, START_DELIM_RST);
    add_row(ROW_RX, STOP_DELIM_RST);
    add_row(ROW_RX, START_DELIM_RST);
    add_row(ROW_RX, 8'h00);
    add_row(ROW_RX, 8'hFF);
    add_row(ROW_RX, STOP_DELIM_RST);
    // idle noise, stray stop
    add_row(ROW_RX, 8'h55);
    add_row(ROW_RX, STOP_DELIM_RST);
    // one byte past a full buffer
    add_row(ROW_RX, START_DELIM_RST);
    add_row(ROW_RX, 8'hA5);
    add_row(ROW_FILL, 8'd65);
    add_row(ROW_RX, STOP_DELIM_RST);
    add_row(ROW_CFG, 8'hAA, REG_SPARE);
    // single byte frame
    add_row(ROW_RX, START_DELIM_RST);
    add_row(ROW_RX, 8'h11);
    add_row(ROW_RX, 8'h77);
    add_row(ROW_RX, STOP_DELIM_RST, '0, 1'b1, '{8'h11, 8'h77, '0, 7'd1, 1'b0, 1'b0, 1'b1});
    add_row(ROW_CFG, 8'h00, REG_START_DELIM);
    add_row(ROW_CFG, 8'hFF, REG_STOP_DELIM);
    add_row(ROW_RX, 8'h00);
    add_row(ROW_RX, 8'h00);
    add_row(ROW_RX, 8'hFF, '0, 1'b1, '{8'h00, 8'h00, '0, '0, 1'b1, 1'b0, 1'b1});

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_RX:   send_byte(plan[i].value, plan[i].typed, plan[i].rec);
        ROW_FILL: repeat (plan[i].value) send_byte(body_byte());
        default:  write_reg(plan[i].idx, plan[i].value);
      endcase
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_START_DELIM, DATA_W'($urandom_range(255)));
          write_reg(REG_STOP_DELIM, DATA_W'($urandom_range(255)));
        end
        1: begin
          gap_pct   = 64;
          stall_pct = 8;
          write_reg(REG_START_DELIM, 8'hFF);
          write_reg(REG_STOP_DELIM, 8'h00);
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
          write_reg(REG_START_DELIM, DATA_W'($urandom_range(255)));
          write_reg(REG_STOP_DELIM, DATA_W'($urandom_range(255)));
        end
      endcase
      target = bytes_sent + 80;
      while (bytes_sent < target) send_frame();
    end

    in_valid_i <= 1'b0;
    while (owed_recs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d rx bytes in %0d random frames plus directed cases, three delimiter settings",
             bytes_sent, frames_sent);
    $display("%0d results checked, %0d mismatches", recs_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
